FILE: src/ffc_pkg.sv
// Shared types and constants for the full-convolution FIR filter.
package ffc_pkg;

  localparam int FUNC_W = 2;
  localparam int IDX_W  = 5;
  localparam int CFG_W  = 6;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_DATA  = 2'd1,
    FUNC_FLUSH = 2'd2
  } func_t;

  // control part of an item travelling down the cell chain
  typedef struct packed {
    logic             vld;
    logic             load;
    logic             emit;
    logic             last;
    logic             clr;
    logic [IDX_W-1:0] idx;
  } tok_ctl_t;

endpackage

FILE: src/ffc_in_if.sv
// Input channel: load, data and flush items.
interface ffc_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                              valid;
  logic                              ready;
  logic [ffc_pkg::FUNC_W-1:0]        func;
  logic [ffc_pkg::IDX_W-1:0]         tap_index;
  logic signed [SAMPLE_BITS-1:0]     value;

  modport source (output valid, func, tap_index, value, input ready);
  modport sink   (input valid, func, tap_index, value, output ready);
endinterface

FILE: src/ffc_out_if.sv
// Output channel: convolution results.
interface ffc_out_if #(
  parameter int RES_W = 37
) ();
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] result;
  logic                    last;

  modport source (output valid, result, last, input ready);
  modport sink   (input valid, result, last, output ready);
endinterface

FILE: src/ffc_feed.sv
// Input stage: turns accepted items into chain items, expands flush into the tail.
module ffc_feed #(
  parameter int SAMPLE_BITS = 16,
  parameter int NW          = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic [NW-1:0]                     n_taps,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ffc_pkg::FUNC_W-1:0]        in_func,
  input  logic [ffc_pkg::IDX_W-1:0]         in_idx,
  input  logic signed [SAMPLE_BITS-1:0]     in_value,
  output ffc_pkg::tok_ctl_t                 tok_ctl,
  output logic signed [SAMPLE_BITS-1:0]     tok_d
);

  logic          busy;
  logic          busy_next;
  logic [NW-1:0] remain;
  logic [NW-1:0] remain_next;
  logic          take;

  assign in_ready = adv && !busy;
  assign take     = in_valid && in_ready;

  always_comb begin
    tok_ctl     = '0;
    tok_d       = '0;
    busy_next   = busy;
    remain_next = remain;
    if (busy) begin
      tok_ctl.vld  = 1'b1;
      tok_ctl.emit = 1'b1;
      if (remain == NW'(1)) begin
        tok_ctl.last = 1'b1;
        tok_ctl.clr  = 1'b1;
        busy_next    = 1'b0;
      end
      remain_next = remain - NW'(1);
    end else if (take) begin
      case (ffc_pkg::func_t'(in_func))
        ffc_pkg::FUNC_LOAD: begin
          tok_ctl.vld  = 1'b1;
          tok_ctl.load = 1'b1;
          tok_ctl.idx  = in_idx;
          tok_d        = in_value;
        end
        ffc_pkg::FUNC_DATA: begin
          tok_ctl.vld  = 1'b1;
          tok_ctl.emit = 1'b1;
          tok_d        = in_value;
        end
        ffc_pkg::FUNC_FLUSH: begin
          tok_ctl.vld = 1'b1;
          if (n_taps == NW'(1)) begin
            tok_ctl.clr = 1'b1;
          end else if (n_taps == NW'(2)) begin
            tok_ctl.emit = 1'b1;
            tok_ctl.last = 1'b1;
            tok_ctl.clr  = 1'b1;
          end else begin
            tok_ctl.emit = 1'b1;
            busy_next    = 1'b1;
            remain_next  = n_taps - NW'(2);
          end
        end
        default: begin
          tok_ctl = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      remain <= '0;
    end else if (adv) begin
      busy   <= busy_next;
      remain <= remain_next;
    end
  end

endmodule

FILE: src/ffc_cell.sv
// One tap cell: holds a coefficient and a history sample, adds its product.
module ffc_cell #(
  parameter int K           = 0,
  parameter int SAMPLE_BITS = 16,
  parameter int RES_W       = 37
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          tap_on,
  input  ffc_pkg::tok_ctl_t             ctl_in,
  input  logic signed [SAMPLE_BITS-1:0] d_in,
  input  logic signed [RES_W-1:0]       acc_in,
  output ffc_pkg::tok_ctl_t             ctl_out,
  output logic signed [SAMPLE_BITS-1:0] d_out,
  output logic signed [RES_W-1:0]       acc_out
);

  localparam bit LOADABLE = K < (1 << ffc_pkg::IDX_W);

  logic signed [SAMPLE_BITS-1:0]   coef;
  logic signed [SAMPLE_BITS-1:0]   hist;
  logic signed [2*SAMPLE_BITS-1:0] prod;
  logic                            hit;

  assign prod = d_in * coef;
  assign hit  = LOADABLE && (ctl_in.idx == ffc_pkg::IDX_W'(K));

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
      coef    <= '0;
      hist    <= '0;
    end else if (adv) begin
      ctl_out <= ctl_in;
      if (ctl_in.vld) begin
        if (ctl_in.load) begin
          if (hit) begin
            coef <= d_in;
          end
        end else begin
          hist <= ctl_in.clr ? '0 : d_in;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (ctl_in.load) begin
        d_out   <= d_in;
        acc_out <= acc_in;
      end else begin
        d_out   <= hist;
        acc_out <= tap_on ? acc_in + RES_W'(prod) : acc_in;
      end
    end
  end

endmodule

FILE: src/fir_full_convolution.sv
// Top level of the streaming full-convolution FIR filter.
// Items flow down a row of TAPS cells, one cell per cycle unless a stalled output freezes
// the whole chain; each cell holds one coefficient and one history sample and adds its
// product into the partial sum carried by the item. A load or data item is taken every cycle
// unless the output stalls or a flush is running; results are registered at the output. A
// flush holds the input as it feeds the zero tail of tap_count-1 results, then the chain
// clears its history. Coefficient loads take effect for every data item that follows them.
module fir_full_convolution #(
  parameter int TAPS        = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [ffc_pkg::CFG_W-1:0]   cfg_wdata,
  ffc_in_if.sink                      din,
  ffc_out_if.source                   dout
);

  localparam int RES_W = 2 * SAMPLE_BITS + $clog2(TAPS);
  localparam int NW    = $clog2(TAPS + 1);

  logic [NW-1:0]               n_taps;
  logic                        adv;
  logic [TAPS-1:0]             tap_on;
  ffc_pkg::tok_ctl_t           ctl [TAPS+1];
  logic signed [SAMPLE_BITS-1:0] d   [TAPS+1];
  logic signed [RES_W-1:0]     acc [TAPS+1];

  // clamp tap count to 1..TAPS
  always_ff @(posedge clk) begin
    if (rst) begin
      n_taps <= NW'(1);
    end else if (cfg_we) begin
      if (cfg_wdata == '0) begin
        n_taps <= NW'(1);
      end else if ({1'b0, cfg_wdata} > (ffc_pkg::CFG_W + 1)'(TAPS)) begin
        n_taps <= NW'(TAPS);
      end else begin
        n_taps <= NW'(cfg_wdata);
      end
    end
  end

  assign adv    = !dout.valid || dout.ready;
  assign acc[0] = '0;

  ffc_feed #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .NW          (NW)
  ) u_feed (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .n_taps   (n_taps),
    .in_valid (din.valid),
    .in_ready (din.ready),
    .in_func  (din.func),
    .in_idx   (din.tap_index),
    .in_value (din.value),
    .tok_ctl  (ctl[0]),
    .tok_d    (d[0])
  );

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    assign tap_on[k] = 32'(n_taps) > k;

    ffc_cell #(
      .K           (k),
      .SAMPLE_BITS (SAMPLE_BITS),
      .RES_W       (RES_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .tap_on  (tap_on[k]),
      .ctl_in  (ctl[k]),
      .d_in    (d[k]),
      .acc_in  (acc[k]),
      .ctl_out (ctl[k+1]),
      .d_out   (d[k+1]),
      .acc_out (acc[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (adv) begin
      dout.valid <= ctl[TAPS].vld && ctl[TAPS].emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dout.result <= acc[TAPS];
      dout.last   <= ctl[TAPS].last;
    end
  end

endmodule
